/* sv/dsdm_pkg.sv */
// Shared types, constants and command codes of the dynamo speed and distance meter.
package dsdm_pkg;

    localparam int unsigned DIVIDEND_W = 34;
    localparam int unsigned DIVISOR_W  = 20;
    localparam int unsigned WORK_W     = 34;
    localparam int unsigned MUL_A_W    = 28;
    localparam int unsigned MUL_B_W    = 28;

    localparam logic [15:0] MIN_PERIOD   = 16'd124;
    localparam logic [16:0] SUM_LIMIT    = 17'd8770;
    localparam logic [16:0] SUM_MAX      = 17'd131071;
    localparam logic [6:0]  COUNT_MAX    = 7'd127;
    localparam logic [12:0] SPEED_MAX    = 13'd8191;
    localparam logic [DIVIDEND_W-1:0] FREQ_NUM = 34'd877000;
    localparam logic [12:0] TEN          = 13'd10;
    localparam logic [MUL_B_W-1:0]    MUL_HUNDRED = 28'd100;
    localparam logic [MUL_B_W-1:0]    MUL_THIRTY_SIX = 28'd36;
    localparam logic [14:0] KM_DM        = 15'd10000;
    localparam logic [11:0] WHEEL_RESET  = 12'd2100;
    localparam logic [3:0]  DIGIT_NINE   = 4'd9;
    localparam logic [3:0]  ROUND_HALF   = 4'd5;

    // Divisions by constants run as reciprocal multiplications. The divisors 28, 1000000 and
    // 36 are split into a power of two, taken off by a shift, and an odd factor; ten is used
    // whole. The rounded-up reciprocal gives the exact quotient over the operand range that occurs here.
    localparam logic [MUL_B_W-1:0] RECIP_7     = 28'd599187;     // ceil(2^22 / 7)
    localparam int unsigned        RECIP_7_SH  = 22;
    localparam logic [MUL_B_W-1:0] RECIP_15625 = 28'd140737489;  // ceil(2^41 / 15625)
    localparam int unsigned        RECIP_M_SH  = 41;
    localparam logic [MUL_B_W-1:0] RECIP_10    = 28'd13108;      // ceil(2^17 / 10)
    localparam int unsigned        RECIP_10_SH = 17;
    localparam logic [MUL_B_W-1:0] RECIP_9     = 28'd466034;     // ceil(2^22 / 9)
    localparam int unsigned        RECIP_9_SH  = 22;

    typedef struct packed {
        logic [15:0] period_ticks;
        logic        display_busy;
    } in_item_t;

    typedef struct packed {
        logic [12:0] speed_raw;
        logic [6:0]  speed_whole;
        logic [3:0]  speed_tenths;
        logic        km_step;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DIV_F,
        OP_MUL_FC,
        OP_MUL_100,
        OP_DIV_28,
        OP_MUL_R,
        OP_MUL_36,
        OP_DIV_M,
        OP_DIV_10A,
        OP_DIV_10B,
        OP_MUL_S100,
        OP_DIV_36,
        OP_DIV_STEP,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
        logic   div_start;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

/* sv/dynamo_speed_distance_meter_top.sv */
// Top level of the dynamo speed and distance meter with its configuration port.
// Each input transaction carries one captured dynamo period in capture clock ticks and a
// display-busy flag. Periods below 124 ticks are dropped without effect; others add into a
// saturating tick sum and a saturating crossing counter. Once the sum reaches 8770 ticks
// while the display is idle, both are snapshotted and cleared and the block computes speed
// in hundredths of km/h, the rounded speed in whole km/h and tenths, and advances the
// distance in decimetres, raising km_step when a kilometre completes. A transaction that
// causes no result is taken without stalling and the next one can follow immediately. A
// transaction that starts a computation holds in_stall high until its result is loaded:
// the two divisions by a variable (by the tick sum and by the frequency) run on one
// restoring divider of 34 steps, the ten multiply and constant-division steps each use
// the shared multiplier, and a final step loads the result. The result sits in an output
// register, so new input transactions are taken while a finished result waits for the
// sink; the next computation only holds longer in its final load step if that earlier
// result is still undelivered. The wheel circumference register sits at byte address 0
// of the APB port and resets to 2100 mm.
module dynamo_speed_distance_meter_top
    import dsdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ADDR_WHEEL = 2'd0;

    logic [11:0] wheel_reg, wheel_next;
    cmd_t        cmd;
    status_t     st;
    logic        ctrl_idle;

    // The single register decodes at every address of the small window.
    always_comb
    begin
        wheel_next = wheel_reg;
        if (psel && penable && pwrite && (paddr[1:0] >= ADDR_WHEEL))
            wheel_next = pwdata[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wheel_reg <= WHEEL_RESET;
        else
            wheel_reg <= wheel_next;
    end

    assign prdata   = {20'd0, wheel_reg};
    assign pready   = 1'b1;
    assign in_stall = !ctrl_idle;

    dsdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .cmd      (cmd),
        .idle     (ctrl_idle)
    );

    dsdm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (in_data),
        .wheel_mm  (wheel_reg),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    // A result is only loaded when the output register is empty or being drained.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result loaded over an undelivered one");

    // A transaction that does not trigger a computation leaves the input open.
    a_no_go_open: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !st.go) |=> !in_stall)
        else $error("input stalled after a non-triggering transaction");

    // The divider never finishes in the cycle right after it is started.
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !st.div_done)
        else $error("divider finished too early");

endmodule

/* sv/dsdm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module dsdm_div
    import dsdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    rem_shift;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = DIVISOR_W'(rem_shift - {1'b0, den_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient  = quo_reg;
    assign done      = done_reg;

endmodule

/* sv/dsdm_datapath.sv */
// Accumulators, shared multiplier, divider and result register of the meter.
module dsdm_datapath
    import dsdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     st,
    input  in_item_t    in_data,
    input  logic [11:0] wheel_mm,
    output out_item_t   out_data,
    output logic        out_valid,
    input  logic        out_stall
);

    logic [16:0] sum_reg, sum_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [13:0] dist_reg, dist_next;
    logic [16:0] t_reg, t_next;
    logic [6:0]  c_reg, c_next;
    logic [6:0]  f_reg, f_next;
    logic [12:0] s_reg, s_next;
    logic [9:0]  s10_reg, s10_next;
    logic [3:0]  r_reg, r_next;
    logic [6:0]  whole_reg, whole_next;
    logic [3:0]  d_reg, d_next;
    logic        km_reg, km_next;
    logic [WORK_W-1:0] w_reg, w_next;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [17:0] sum_add;
    logic [16:0] sum_sat;
    logic [6:0]  cnt_sat;
    logic        period_ok;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] product;
    logic [14:0] mega_q;
    logic [9:0]  dec_q;
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_num;
    logic [DIVISOR_W-1:0]  div_den;
    logic [DIVIDEND_W-1:0] div_q;
    logic                  div_done;
    logic [14:0] dist_add;

    dsdm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .quotient  (div_q),
        .done      (div_done)
    );

    assign div_start = cmd.div_start;
    assign sum_add   = {1'b0, sum_reg} + {2'b0, in_data.period_ticks};
    assign sum_sat   = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[16:0];
    assign cnt_sat   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign period_ok = (in_data.period_ticks >= MIN_PERIOD);
    assign product   = mul_a * mul_b;
    assign mega_q    = 15'(product >> RECIP_M_SH);
    assign dec_q     = 10'(product >> RECIP_10_SH);
    assign dist_add  = {1'b0, dist_reg} + {1'b0, div_q[13:0]};

    assign st.go       = period_ok && (sum_sat >= SUM_LIMIT) && !in_data.display_busy;
    assign st.div_done = div_done;
    assign st.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (cmd.op)
            OP_MUL_FC:   begin mul_a = MUL_A_W'(f_reg); mul_b = MUL_B_W'(c_reg); end
            OP_DIV_28:   begin mul_a = w_reg[29:2]; mul_b = RECIP_7; end
            OP_MUL_R:    begin mul_a = w_reg[MUL_A_W-1:0]; mul_b = MUL_B_W'(wheel_mm); end
            OP_MUL_36:   begin mul_a = w_reg[MUL_A_W-1:0]; mul_b = MUL_THIRTY_SIX; end
            OP_DIV_M:    begin mul_a = w_reg[33:6]; mul_b = RECIP_15625; end
            OP_DIV_10A:  begin mul_a = MUL_A_W'(s_reg); mul_b = RECIP_10; end
            OP_DIV_10B:  begin mul_a = MUL_A_W'(s10_reg); mul_b = RECIP_10; end
            OP_MUL_S100: begin mul_a = MUL_A_W'(s_reg); mul_b = MUL_HUNDRED; end
            OP_DIV_36:   begin mul_a = w_reg[29:2]; mul_b = RECIP_9; end
            default:     begin mul_a = w_reg[MUL_A_W-1:0]; mul_b = MUL_HUNDRED; end
        endcase
        case (cmd.op)
            OP_DIV_F:    begin div_num = FREQ_NUM; div_den = DIVISOR_W'(t_reg); end
            default:     begin div_num = w_reg; div_den = DIVISOR_W'(f_reg); end
        endcase
    end

    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        dist_next      = dist_reg;
        t_next         = t_reg;
        c_next         = c_reg;
        f_next         = f_reg;
        s_next         = s_reg;
        s10_next       = s10_reg;
        r_next         = r_reg;
        whole_next     = whole_reg;
        d_next         = d_reg;
        km_next        = km_reg;
        w_next         = w_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.accept && period_ok)
        begin
            if (st.go)
            begin
                t_next   = sum_sat;
                c_next   = cnt_sat;
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_sat;
                cnt_next = cnt_sat;
            end
        end

        case (cmd.op)
            OP_MUL_FC, OP_MUL_100, OP_MUL_R, OP_MUL_36:
                w_next = WORK_W'(product);
            OP_DIV_28:
                w_next = WORK_W'(product >> RECIP_7_SH);
            OP_DIV_M:
                s_next = (mega_q >= 15'd4096) ? SPEED_MAX : {mega_q[11:0], 1'b0};
            OP_DIV_10A:
                s10_next = dec_q;
            OP_DIV_10B:
            begin
                whole_next = dec_q[6:0];
                r_next     = 4'(s_reg - 13'(s10_reg) * TEN);
            end
            OP_MUL_S100:
            begin
                w_next = WORK_W'(product);
                d_next = 4'(s10_reg - 10'(whole_reg) * 10'(TEN));
            end
            OP_DIV_36:
                w_next = WORK_W'(product >> RECIP_9_SH);
            OP_OUT:
                if (cmd.out_load)
                begin
                    out_valid_next        = 1'b1;
                    out_next.speed_raw    = s_reg;
                    out_next.km_step      = km_reg;
                    out_next.speed_whole  = whole_reg;
                    out_next.speed_tenths = d_reg;
                    if (r_reg >= ROUND_HALF)
                    begin
                        if (d_reg == DIGIT_NINE)
                        begin
                            out_next.speed_whole  = whole_reg + 1'b1;
                            out_next.speed_tenths = '0;
                        end
                        else
                        begin
                            out_next.speed_tenths = d_reg + 1'b1;
                        end
                    end
                end
            default:
                ;
        endcase

        if (div_done)
        begin
            case (cmd.op)
                OP_DIV_F:   f_next = div_q[6:0];
                OP_DIV_STEP:
                begin
                    if (dist_add > KM_DM)
                    begin
                        dist_next = 14'(dist_add - KM_DM);
                        km_next   = 1'b1;
                    end
                    else
                    begin
                        dist_next = dist_add[13:0];
                        km_next   = 1'b0;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            dist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            dist_reg      <= dist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        c_reg     <= c_next;
        f_reg     <= f_next;
        s_reg     <= s_next;
        s10_reg   <= s10_next;
        r_reg     <= r_next;
        whole_reg <= whole_next;
        d_reg     <= d_next;
        km_reg    <= km_next;
        w_reg     <= w_next;
        out_reg   <= out_next;
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

/* sv/dsdm_ctrl.sv */
// Sequencer that steps the datapath through one speed and distance computation.
module dsdm_ctrl
    import dsdm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t st,
    output cmd_t    cmd,
    output logic    idle
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DIV_F    = 14'b00000000000010,
        S_MUL_FC   = 14'b00000000000100,
        S_MUL_100  = 14'b00000000001000,
        S_DIV_28   = 14'b00000000010000,
        S_MUL_R    = 14'b00000000100000,
        S_MUL_36   = 14'b00000001000000,
        S_DIV_M    = 14'b00000010000000,
        S_DIV_10A  = 14'b00000100000000,
        S_DIV_10B  = 14'b00001000000000,
        S_MUL_S100 = 14'b00010000000000,
        S_DIV_36   = 14'b00100000000000,
        S_DIV_STEP = 14'b01000000000000,
        S_OUT      = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;
    logic   next_is_div;

    // Divisions by constants are reciprocal multiply steps; only the
    // divisions by the snapshot sum and by the frequency use the serial divider.
    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_IDLE;
        cmd.accept    = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.div_start = first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && st.go)
                    state_next = S_DIV_F;
            end
            S_DIV_F:
            begin
                cmd.op = OP_DIV_F;
                if (st.div_done)
                    state_next = S_MUL_FC;
            end
            S_MUL_FC:
            begin
                cmd.op     = OP_MUL_FC;
                state_next = S_MUL_100;
            end
            S_MUL_100:
            begin
                cmd.op     = OP_MUL_100;
                state_next = S_DIV_28;
            end
            S_DIV_28:
            begin
                cmd.op     = OP_DIV_28;
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                cmd.op     = OP_MUL_R;
                state_next = S_MUL_36;
            end
            S_MUL_36:
            begin
                cmd.op     = OP_MUL_36;
                state_next = S_DIV_M;
            end
            S_DIV_M:
            begin
                cmd.op     = OP_DIV_M;
                state_next = S_DIV_10A;
            end
            S_DIV_10A:
            begin
                cmd.op     = OP_DIV_10A;
                state_next = S_DIV_10B;
            end
            S_DIV_10B:
            begin
                cmd.op     = OP_DIV_10B;
                state_next = S_MUL_S100;
            end
            S_MUL_S100:
            begin
                cmd.op     = OP_MUL_S100;
                state_next = S_DIV_36;
            end
            S_DIV_36:
            begin
                cmd.op     = OP_DIV_36;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op = OP_DIV_STEP;
                if (st.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.op = OP_OUT;
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (state_next)
            S_DIV_F, S_DIV_STEP:
                next_is_div = 1'b1;
            default:
                next_is_div = 1'b0;
        endcase
        first_next = next_is_div && (state_next != state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

endmodule

/* test/tb_dynamo_speed_distance_meter_top.sv */
// Testbench for the dynamo speed and distance meter: directed and random periods checked
// against an in-bench model of speed, rounding and distance.
module tb_dynamo_speed_distance_meter_top;
    import dsdm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Byte address of the wheel circumference register.
    localparam logic [1:0] ADDR_WHEEL = 2'd0;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    dynamo_speed_distance_meter_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Model state, kept beside the block so that every snapshot can be predicted.
    logic [11:0] wheel_mm;
    logic [16:0] sum_ticks;
    logic [6:0]  crossings;
    logic [13:0] dist_dm;

    out_item_t speed_queue[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned items_sent;
    int unsigned cycle_count;
    bit          sink_idle_on;
    bit          source_idle_on;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Cycle limit: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Apply one period to the model; returns 1 and the expected result on a snapshot.
    function automatic bit predict_snapshot(input in_item_t item, output out_item_t res);
        logic [63:0] t, c, f, s, step;
        logic [63:0] r, d, whole, tenths;
        logic [31:0] sum_wide;
        logic [14:0] dist_wide;
        res = '0;
        if (item.period_ticks < MIN_PERIOD)
            return 1'b0;
        sum_wide = sum_ticks + item.period_ticks;
        sum_ticks = (sum_wide > SUM_MAX) ? SUM_MAX : sum_wide[16:0];
        if (crossings < COUNT_MAX)
            crossings = crossings + 1;
        if (sum_ticks < SUM_LIMIT || item.display_busy)
            return 1'b0;
        t = sum_ticks;
        c = crossings;
        sum_ticks = '0;
        crossings = '0;
        f = 64'd877000 / t;
        s = f * (c * 100) / 28;
        s = s * wheel_mm * 36 / 1000000 * 2;
        if (s > SPEED_MAX)
            s = SPEED_MAX;
        r = s % 10;
        d = (s / 10) % 10;
        whole = s / 100;
        tenths = d;
        if (r >= 5)
        begin
            if (d == 9)
            begin
                whole = whole + 1;
                tenths = 0;
            end
            else
                tenths = d + 1;
        end
        step = (s * 100 / 36) / f;
        dist_wide = dist_dm + step[14:0];
        res.km_step = 1'b0;
        if (dist_wide > KM_DM)
        begin
            dist_wide = dist_wide - KM_DM;
            res.km_step = 1'b1;
        end
        dist_dm = dist_wide[13:0];
        res.speed_raw = s[12:0];
        res.speed_whole = whole[6:0];
        res.speed_tenths = tenths[3:0];
        return 1'b1;
    endfunction

    // Sends one transaction, idling at random beforehand, and predicts its result.
    // Valid stays high after acceptance so that the next transaction can follow at once.
    task automatic send_period(input logic [15:0] period, input logic busy);
        in_item_t  item;
        out_item_t res;
        while (source_idle_on && $urandom_range(99, 0) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        item.period_ticks = period;
        item.display_busy = busy;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Accepted at this edge; the model sees it now.
        if (predict_snapshot(item, res))
            speed_queue.push_back(res);
        items_sent++;
    endtask

    // Waits for all expected results and then for the divider to go quiet.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (speed_queue.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Writes the wheel circumference while the block is idle.
    task automatic write_wheel(input logic [11:0] mm);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WHEEL;
        pwdata  <= {20'd0, mm};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        wheel_mm = mm;
    endtask

    // Result checker: each accepted result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (speed_queue.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = speed_queue.pop_front();
                if (out_data.speed_raw !== want.speed_raw)
                begin
                    $display("%0t: speed_raw expected %0d actual %0d", $time,
                             want.speed_raw, out_data.speed_raw);
                    errors++;
                end
                if (out_data.speed_whole !== want.speed_whole)
                begin
                    $display("%0t: speed_whole expected %0d actual %0d", $time,
                             want.speed_whole, out_data.speed_whole);
                    errors++;
                end
                if (out_data.speed_tenths !== want.speed_tenths)
                begin
                    $display("%0t: speed_tenths expected %0d actual %0d", $time,
                             want.speed_tenths, out_data.speed_tenths);
                    errors++;
                end
                if (out_data.km_step !== want.km_step)
                begin
                    $display("%0t: km_step expected %0d actual %0d", $time,
                             want.km_step, out_data.km_step);
                    errors++;
                end
            end
        end
    end

    // Sink stall: random with a chance of about 17 percent while enabled.
    always @(posedge clk)
    begin
        out_stall <= sink_idle_on && ($urandom_range(99, 0) < 17);
    end

    // Edge cases of the period: zero, just below and at the acceptance limit, the largest
    // value, a busy display that holds the snapshot, and both saturations.
    task automatic test_period_edges();
        send_period(16'd0, 1'b0);
        send_period(16'd123, 1'b0);
        send_period(16'd124, 1'b0);
        send_period(16'hFFFF, 1'b0);
        send_period(16'd8770, 1'b0);
        send_period(16'd8769, 1'b0);
        send_period(16'd1, 1'b0);
        send_period(16'hFFFF, 1'b1);
        send_period(16'hFFFF, 1'b1);
        send_period(16'hFFFF, 1'b1);
        send_period(16'd124, 1'b0);
        for (int i = 0; i < 130; i++)
            send_period(16'd124, 1'b1);
        send_period(16'd124, 1'b0);
    endtask

    // Fast wheel periods with the largest wheel push the speed toward its top; a zero
    // wheel gives zero speed.
    task automatic test_speed_limit();
        write_wheel(12'd4095);
        for (int i = 0; i < 71; i++)
            send_period(16'd124, 1'b0);
        write_wheel(12'd0);
        for (int i = 0; i < 5; i++)
            send_period(16'd2000, 1'b0);
    endtask

    // Random periods: mostly realistic ones so that snapshots come often, some noise.
    task automatic test_random_ride(input int unsigned count);
        logic [15:0] p;
        for (int unsigned i = 0; i < count; i++)
        begin
            case ($urandom_range(9, 0))
                0: p = $urandom_range(123, 0);
                1: p = $urandom_range(65535, 0);
                default: p = $urandom_range(3000, 124);
            endcase
            send_period(p, ($urandom_range(5, 0) == 0));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        cycle_count = 0;
        sink_idle_on = 1'b0;
        source_idle_on = 1'b0;
        wheel_mm = WHEEL_RESET;
        sum_ticks = '0;
        crossings = '0;
        dist_dm = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part runs with no idling on either side.
        test_period_edges();
        test_speed_limit();
        write_wheel(12'd2100);
        sink_idle_on = 1'b1;
        source_idle_on = 1'b1;
        test_random_ride(250);
        write_wheel(12'd700);
        test_random_ride(175);
        write_wheel(12'd4095);
        test_random_ride(175);
        drain_results();

        $display("Sent %0d periods over several wheel sizes; %0d speed results checked.",
                 items_sent, results_seen);
        if (errors == 0 && speed_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
